// File: design/lru_page_cache_directory_unit_assert.svh
// Assertion macros for the page cache directory.
`ifndef LRU_PAGE_CACHE_DIRECTORY_UNIT_ASSERT_SVH
`define LRU_PAGE_CACHE_DIRECTORY_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define LPCD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define LPCD_ASSERT_IMP(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Check that a trigger implies a condition in the next cycle.
`define LPCD_ASSERT_NXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// File: design/lpcd_pkg.sv
// Constants and types of the page cache directory.
`timescale 1ns / 1ps
package lpcd_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int USED_W    = SLOT_W + 1;
  localparam int PAGE_BITS = 14;
  localparam int ADDR_W    = 32;
  localparam int PAGE_W    = ADDR_W - PAGE_BITS;
  localparam int REGIONS   = 256;
  localparam int REGION_W  = 8;
  localparam int STAMP_W   = 64;
  localparam int CNT_W     = 32;
  localparam int REQ_W     = 2;

  localparam logic [ADDR_W:0]   PAGE_SPAN   = (ADDR_W + 1)'(1) << PAGE_BITS;
  localparam logic [REGION_W:0] REGIONS_LIM = (REGION_W + 1)'(REGIONS);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP    = 2'd0,
    REQ_INV_RANGE = 2'd1,
    REQ_INV_ALL   = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

// File: design/lru_page_cache_directory_unit.sv
// Page cache tag directory with timestamp LRU replacement, top level.
//
// Usage: drive req_type, region_num, byte_offset and range_len and raise start
// while busy is low; the word is taken at that clock edge. busy then stays high
// through the scan and update states: the scan visits the slots one per cycle
// through a single tag comparator, a single 64-bit stamp comparator and a
// single range-overlap check, and the update writes the chosen slot, the tick
// and the counters. In the cycle after that, done is high for exactly one
// cycle with hit, fill_needed, slot_index, page_base, pages_used, hit_count
// and miss_count. A new word may be started in that same cycle, not before.
// The receiver cannot stall; done is a one-cycle strobe and the result must
// be taken when it shows.
// Reset (rst, synchronous) empties every slot and clears the tick and both
// counters; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
module lru_page_cache_directory_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lpcd_pkg::REQ_W-1:0]    req_type,
  input  logic [lpcd_pkg::REGION_W-1:0] region_num,
  input  logic [lpcd_pkg::ADDR_W-1:0]   byte_offset,
  input  logic [lpcd_pkg::ADDR_W-1:0]   range_len,
  output logic                          done,
  output logic                          hit,
  output logic                          fill_needed,
  output logic [lpcd_pkg::SLOT_W-1:0]   slot_index,
  output logic [lpcd_pkg::ADDR_W-1:0]   page_base,
  output logic [lpcd_pkg::USED_W-1:0]   pages_used,
  output logic [lpcd_pkg::CNT_W-1:0]    hit_count,
  output logic [lpcd_pkg::CNT_W-1:0]    miss_count
);
  import lpcd_pkg::*;

  state_t state, state_next;
  logic   scan_en, upd_en;

  // Latched request
  logic [REQ_W-1:0]    rq_type;
  logic [REGION_W-1:0] rq_region;
  logic [ADDR_W-1:0]   rq_start;
  logic [ADDR_W:0]     rq_end;

  // Directory
  logic [SLOTS-1:0]    slot_valid;
  logic [REGION_W-1:0] slot_region [SLOTS];
  logic [PAGE_W-1:0]   slot_page   [SLOTS];
  logic [STAMP_W-1:0]  slot_stamp  [SLOTS];
  logic [STAMP_W-1:0]  global_tick;
  logic [CNT_W-1:0]    hit_total;
  logic [CNT_W-1:0]    miss_total;
  logic [USED_W-1:0]   used_cnt;

  // Scan state
  logic [SLOT_W-1:0]   scan_idx;
  logic                found;
  logic [SLOT_W-1:0]   found_idx;
  logic [SLOT_W-1:0]   best_idx;
  logic [STAMP_W-1:0]  best_stamp;

  // Scan datapath
  logic                region_ok, is_lookup, is_range, scan_last;
  logic [PAGE_W-1:0]   rq_page;
  logic                cur_valid, cur_match, cur_region_eq, cur_overlap;
  logic [STAMP_W-1:0]  cur_stamp;
  logic [ADDR_W-1:0]   cur_pstart;
  logic [ADDR_W:0]     cur_pend;
  logic [STAMP_W-1:0]  tick_inc;
  logic [SLOT_W-1:0]   upd_idx;

  assign region_ok  = ({1'b0, rq_region} < REGIONS_LIM);
  assign is_lookup  = (rq_type == REQ_LOOKUP) && region_ok;
  assign is_range   = (rq_type == REQ_INV_RANGE) && region_ok;
  assign rq_page    = rq_start[ADDR_W-1:PAGE_BITS];
  assign scan_last  = (scan_idx == SLOT_W'(SLOTS - 1));

  assign cur_valid     = slot_valid[scan_idx];
  assign cur_region_eq = (slot_region[scan_idx] == rq_region);
  assign cur_match     = cur_valid && cur_region_eq && (slot_page[scan_idx] == rq_page);
  // A free slot counts as stamp zero.
  assign cur_stamp     = cur_valid ? slot_stamp[scan_idx] : '0;
  assign cur_pstart    = {slot_page[scan_idx], {PAGE_BITS{1'b0}}};
  assign cur_pend      = {1'b0, cur_pstart} + PAGE_SPAN;
  assign cur_overlap   = ({1'b0, rq_start} < cur_pend) && (rq_end > {1'b0, cur_pstart});

  assign tick_inc = global_tick + STAMP_W'(1);
  assign upd_idx  = found ? found_idx : best_idx;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy    = 1'b1;
    scan_en = 1'b0;
    upd_en  = 1'b0;
    case (state)
      ST_IDLE:   busy = 1'b0;
      ST_SCAN:   scan_en = 1'b1;
      ST_UPDATE: upd_en = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (!busy && start) begin
      rq_type   <= req_type;
      rq_region <= region_num;
      rq_start  <= byte_offset;
      rq_end    <= {1'b0, byte_offset} + {1'b0, range_len};
    end
    if (rst) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (!busy && start) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (scan_en) begin
      scan_idx <= scan_idx + SLOT_W'(1);
      if (cur_match && !found) begin
        found     <= 1'b1;
        found_idx <= scan_idx;
      end
      // Strict compare keeps the lowest index on ties.
      if (scan_idx == '0 || cur_stamp < best_stamp) begin
        best_stamp <= cur_stamp;
        best_idx   <= scan_idx;
      end
    end
  end

  // Directory, counters and result
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      global_tick <= '0;
      hit_total   <= '0;
      miss_total  <= '0;
      used_cnt    <= '0;
      done        <= 1'b0;
    end else begin
      done <= upd_en;
      if (scan_en && is_range && cur_valid && cur_region_eq && cur_overlap) begin
        slot_valid[scan_idx] <= 1'b0;
        used_cnt             <= used_cnt - USED_W'(1);
      end
      if (upd_en) begin
        hit         <= 1'b0;
        fill_needed <= 1'b0;
        slot_index  <= '0;
        page_base   <= '0;
        if (is_lookup) begin
          global_tick         <= tick_inc;
          slot_stamp[upd_idx] <= tick_inc;
          slot_index          <= upd_idx;
          page_base           <= {rq_page, {PAGE_BITS{1'b0}}};
          if (found) begin
            hit       <= 1'b1;
            hit_total <= (hit_total == '1) ? hit_total : hit_total + CNT_W'(1);
          end else begin
            fill_needed           <= 1'b1;
            miss_total            <= (miss_total == '1) ? miss_total : miss_total + CNT_W'(1);
            slot_valid[best_idx]  <= 1'b1;
            slot_region[best_idx] <= rq_region;
            slot_page[best_idx]   <= rq_page;
            if (!slot_valid[best_idx]) begin
              used_cnt <= used_cnt + USED_W'(1);
            end
          end
        end else if (rq_type == REQ_INV_ALL) begin
          slot_valid <= '0;
          used_cnt   <= '0;
          hit_total  <= '0;
          miss_total <= '0;
        end
      end
    end
  end

  assign pages_used = used_cnt;
  assign hit_count  = hit_total;
  assign miss_count = miss_total;

`include "lru_page_cache_directory_unit_assert.svh"

  `LPCD_ASSERT(a_used_matches_valid, used_cnt == USED_W'($countones(slot_valid)), "slot count out of step with valid bits")
  `LPCD_ASSERT_IMP(a_hit_or_fill, done, !(hit && fill_needed), "hit and fill in one result")
  `LPCD_ASSERT_NXT(a_start_busy, start && !busy, busy && scan_idx == '0, "accepted word did not start a scan")
  `LPCD_ASSERT_IMP(a_done_after_update, done, !busy && $past(upd_en), "result without an update cycle")

endmodule

// File: test/tb_lru_page_cache_directory_unit.sv
// Testbench for the page cache tag directory: directed and random requests checked per word.
`timescale 1ns / 1ps
module tb_lru_page_cache_directory_unit;
  import lpcd_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned END_PAUSE = 40;

  typedef struct packed {
    logic                hit;
    logic                fill;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   base;
    logic [USED_W-1:0]   used;
    logic [CNT_W-1:0]    hits;
    logic [CNT_W-1:0]    misses;
  } dir_status_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start;
  logic                busy;
  logic [REQ_W-1:0]    req_type;
  logic [REGION_W-1:0] region_num;
  logic [ADDR_W-1:0]   byte_offset;
  logic [ADDR_W-1:0]   range_len;
  logic                done;
  logic                hit;
  logic                fill_needed;
  logic [SLOT_W-1:0]   slot_index;
  logic [ADDR_W-1:0]   page_base;
  logic [USED_W-1:0]   pages_used;
  logic [CNT_W-1:0]    hit_count;
  logic [CNT_W-1:0]    miss_count;

  // Shadow copy of the directory
  logic                ent_valid [SLOTS];
  logic [REGION_W-1:0] ent_region [SLOTS];
  logic [PAGE_W-1:0]   ent_page [SLOTS];
  logic [STAMP_W-1:0]  ent_stamp [SLOTS];
  logic [STAMP_W-1:0]  lru_clock;
  logic [CNT_W-1:0]    hits_seen;
  logic [CNT_W-1:0]    misses_seen;

  dir_status_t status_q [$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned steady_left = 0;
  bit          steady = 1'b0;

  lru_page_cache_directory_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .region_num  (region_num),
    .byte_offset (byte_offset),
    .range_len   (range_len),
    .done        (done),
    .hit         (hit),
    .fill_needed (fill_needed),
    .slot_index  (slot_index),
    .page_base   (page_base),
    .pages_used  (pages_used),
    .hit_count   (hit_count),
    .miss_count  (miss_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Apply one request to the shadow directory and return the status word it produces.
  function automatic dir_status_t apply_to_directory(input logic [REQ_W-1:0] kind,
                                                     input logic [REGION_W-1:0] region,
                                                     input logic [ADDR_W-1:0] offset,
                                                     input logic [ADDR_W-1:0] len);
    dir_status_t st;
    logic [PAGE_W-1:0] page;
    logic [ADDR_W:0] lo, hi, pg_lo, pg_hi;
    int found, victim, used;
    st = '0;
    if (kind == REQ_LOOKUP && int'(region) < REGIONS) begin
      page = offset[ADDR_W-1:PAGE_BITS];
      st.base = {page, {PAGE_BITS{1'b0}}};
      found = -1;
      for (int i = 0; i < SLOTS; i++)
        if (found < 0 && ent_valid[i] && ent_region[i] == region && ent_page[i] == page)
          found = i;
      lru_clock = lru_clock + 1'b1;
      if (found >= 0) begin
        hits_seen = sat_bump(hits_seen);
        ent_stamp[found] = lru_clock;
        st.hit = 1'b1;
        st.slot = SLOT_W'(found);
      end else begin
        // Oldest stamp wins, lowest index on ties; empty slots sit at zero
        victim = 0;
        for (int i = 1; i < SLOTS; i++)
          if (ent_stamp[i] < ent_stamp[victim]) victim = i;
        misses_seen = sat_bump(misses_seen);
        ent_valid[victim] = 1'b1;
        ent_region[victim] = region;
        ent_page[victim] = page;
        ent_stamp[victim] = lru_clock;
        st.fill = 1'b1;
        st.slot = SLOT_W'(victim);
      end
    end else if (kind == REQ_INV_RANGE && int'(region) < REGIONS) begin
      // Range end is kept one bit wider so it never wraps
      lo = {1'b0, offset};
      hi = lo + {1'b0, len};
      for (int i = 0; i < SLOTS; i++) begin
        if (ent_valid[i] && ent_region[i] == region) begin
          pg_lo = {1'b0, ent_page[i], {PAGE_BITS{1'b0}}};
          pg_hi = pg_lo + PAGE_SPAN;
          if (lo < pg_hi && hi > pg_lo) begin
            ent_valid[i] = 1'b0;
            ent_stamp[i] = '0;
          end
        end
      end
    end else if (kind == REQ_INV_ALL) begin
      for (int i = 0; i < SLOTS; i++) begin
        ent_valid[i] = 1'b0;
        ent_stamp[i] = '0;
      end
      hits_seen = '0;
      misses_seen = '0;
    end
    used = 0;
    for (int i = 0; i < SLOTS; i++)
      if (ent_valid[i]) used++;
    st.used = USED_W'(used);
    st.hits = hits_seen;
    st.misses = misses_seen;
    return st;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [ADDR_W-1:0] got,
                               input logic [ADDR_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Send one word; keep start high on return so a back-to-back word needs no toggle.
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [REGION_W-1:0] region,
                          input logic [ADDR_W-1:0] offset, input logic [ADDR_W-1:0] len);
    int unsigned gap;
    if (steady_left == 0) begin
      steady = ($urandom_range(0, 3) == 0);
      steady_left = $urandom_range(8, 40);
    end
    steady_left--;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= kind;
    region_num <= region;
    byte_offset <= offset;
    range_len <= len;
    do @(posedge clk); while (busy);
    status_q.push_back(apply_to_directory(kind, region, offset, len));
  endtask

  function automatic logic [REGION_W-1:0] hot_region(input int unsigned n);
    case ($urandom_range(0, n - 1))
      0:       return 8'h00;
      1:       return 8'hA5;
      2:       return 8'h5A;
      default: return 8'hFF;
    endcase
  endfunction

  // Small page pool, mirrored to the top of the offset space half the time
  function automatic logic [PAGE_W-1:0] hot_page(input int unsigned spread);
    logic [PAGE_W-1:0] p;
    p = PAGE_W'($urandom_range(0, spread - 1));
    return $urandom_range(0, 1) ? ~p : p;
  endfunction

  function automatic logic [ADDR_W-1:0] hot_offset(input int unsigned spread);
    return {hot_page(spread), PAGE_BITS'($urandom)};
  endfunction

  task automatic pick_range(output logic [ADDR_W-1:0] offset, output logic [ADDR_W-1:0] len);
    offset = {hot_page(8), {PAGE_BITS{1'b0}}} + ADDR_W'($urandom_range(0, 32'h7FFF))
             - ADDR_W'(32'h4000);
    case ($urandom_range(0, 4))
      0:       len = '0;
      1:       len = ADDR_W'(1);
      2:       len = ADDR_W'($urandom_range(1, 32'h4000));
      3:       len = ADDR_W'($urandom_range(32'h4000, 32'h30000));
      default: len = $urandom;
    endcase
  endtask

  task automatic test_directed_cases();
    send_req(REQ_LOOKUP, 8'h00, 32'h0000_0000, '0);
    send_req(REQ_LOOKUP, 8'h00, 32'h0000_3FFF, '0);
    send_req(REQ_LOOKUP, 8'hFF, 32'hFFFF_FFFF, '1);
    send_req(REQ_LOOKUP, 8'hFF, 32'hFFFF_C000, '0);
    send_req(REQ_LOOKUP, 8'h00, 32'h0000_4000, '0);
    send_req(REQ_LOOKUP, 8'h01, 32'h0000_0000, '0);
    // Zero length frees nothing
    send_req(REQ_INV_RANGE, 8'h00, 32'h0000_0000, '0);
    // Range ending exactly at the next page keeps that page
    send_req(REQ_INV_RANGE, 8'h00, 32'h0000_0000, 32'h0000_4000);
    send_req(REQ_INV_RANGE, 8'h02, 32'h0000_0000, '1);
    // Last byte of a page still overlaps it
    send_req(REQ_INV_RANGE, 8'h01, 32'h0000_3FFF, 32'h0000_0001);
    // Offset plus length past 2^32 must not wrap
    send_req(REQ_INV_RANGE, 8'hFF, 32'hFFFF_FFFF, '1);
    send_req(REQ_UNUSED, 8'hFF, '1, '1);
    send_req(REQ_LOOKUP, 8'h00, 32'h0000_4ABC, '0);
    send_req(REQ_INV_ALL, 8'hFF, '1, '1);
    send_req(REQ_LOOKUP, 8'h00, 32'h0000_4000, '0);
    send_req(REQ_UNUSED, 8'h00, '0, '0);
    send_req(REQ_INV_ALL, 8'h00, '0, '0);
  endtask

  task automatic test_lru_replacement();
    send_req(REQ_INV_ALL, 8'h00, '0, '0);
    // Working set that fits, then one that thrashes
    repeat (200) send_req(REQ_LOOKUP, hot_region(2), hot_offset(3), $urandom);
    repeat (200) send_req(REQ_LOOKUP, hot_region(4), hot_offset(4), $urandom);
  endtask

  task automatic test_range_invalidation();
    logic [ADDR_W-1:0] offset, len;
    repeat (400) begin
      if ($urandom_range(0, 9) < 6) begin
        send_req(REQ_LOOKUP, hot_region(4), hot_offset(4), $urandom);
      end else begin
        pick_range(offset, len);
        send_req(REQ_INV_RANGE, hot_region(4), offset, len);
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0] offset, len;
    int unsigned pick;
    repeat (530) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_req(REQ_LOOKUP, hot_region(4), hot_offset(6), $urandom);
      end else if (pick < 65) begin
        send_req(REQ_LOOKUP, REGION_W'($urandom), $urandom, $urandom);
      end else if (pick < 85) begin
        pick_range(offset, len);
        send_req(REQ_INV_RANGE, hot_region(4), offset, len);
      end else if (pick < 91) begin
        send_req(REQ_INV_RANGE, REGION_W'($urandom), $urandom, $urandom);
      end else if (pick < 95) begin
        send_req(REQ_INV_ALL, REGION_W'($urandom), $urandom, $urandom);
      end else begin
        send_req(REQ_UNUSED, REGION_W'($urandom), $urandom, $urandom);
      end
    end
  endtask

  always @(posedge clk) begin : check_status
    dir_status_t want;
    if (!rst && done) begin
      if (status_q.size() == 0) begin
        report_mismatch("result word with no request outstanding");
      end else begin
        want = status_q.pop_front();
        compare_field("hit", ADDR_W'(hit), ADDR_W'(want.hit));
        compare_field("fill_needed", ADDR_W'(fill_needed), ADDR_W'(want.fill));
        compare_field("slot_index", ADDR_W'(slot_index), ADDR_W'(want.slot));
        compare_field("page_base", page_base, want.base);
        compare_field("pages_used", ADDR_W'(pages_used), ADDR_W'(want.used));
        compare_field("hit_count", hit_count, want.hits);
        compare_field("miss_count", miss_count, want.misses);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("lru_page_cache_directory_unit test failed");
      $finish;
    end
  end

  initial begin
    start <= 1'b0;
    req_type <= REQ_LOOKUP;
    region_num <= '0;
    byte_offset <= '0;
    range_len <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      ent_valid[i] = 1'b0;
      ent_region[i] = '0;
      ent_page[i] = '0;
      ent_stamp[i] = '0;
    end
    lru_clock = '0;
    hits_seen = '0;
    misses_seen = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_lru_replacement();
    test_range_invalidation();
    test_random_traffic();

    // Drain outstanding words, then watch for stray strobes
    start <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (END_PAUSE) @(posedge clk);
    if (mismatches == 0)
      $display("lru_page_cache_directory_unit test passed");
    else
      $display("lru_page_cache_directory_unit test failed");
    $finish;
  end

endmodule
